@@ src/tlpc_pkg.sv @@
// Shared types, codes and helper functions of the traffic light phase controller.
`default_nettype none

package tlpc_pkg;

   localparam int TickWidth  = 24;
   localparam int CountWidth = 16;
   localparam int BlinkWidth = 7;

   localparam logic [TickWidth-1:0]  TICK_MAX  = '1;
   localparam logic [CountWidth-1:0] COUNT_MAX = '1;
   localparam logic [BlinkWidth-1:0] NIGHT_BLINKS = 7'd100;

   // Reset values of the timing registers.
   localparam logic [TickWidth-1:0] MIN_GREEN_RESET   = 24'd5000;
   localparam logic [TickWidth-1:0] YELLOW_RESET      = 24'd3000;
   localparam logic [TickWidth-1:0] ALL_RED_RESET     = 24'd1000;
   localparam logic [TickWidth-1:0] SEC_GREEN_RESET   = 24'd5000;
   localparam logic [TickWidth-1:0] STARTUP_OFF_RESET = 24'd5000;
   localparam logic [TickWidth-1:0] BLINK_HALF_RESET  = 24'd500;
   localparam logic [TickWidth-1:0] SPEED_LIMIT_RESET = 24'd55;

   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_PRESS     = 3'd1,
      CMD_GATE_A    = 3'd2,
      CMD_GATE_B    = 3'd3,
      CMD_STOP_LINE = 3'd4,
      CMD_MODE      = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_NONE      = 2'd0,
      MODE_EMERGENCY = 2'd1,
      MODE_NIGHT     = 2'd2,
      MODE_CLOSE     = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      LAMP_OFF    = 2'd0,
      LAMP_GREEN  = 2'd1,
      LAMP_YELLOW = 2'd2,
      LAMP_RED    = 2'd3
   } lamp_type;

   typedef enum logic [3:0] {
      PH_STARTUP = 4'd0,
      PH_GREEN   = 4'd1,
      PH_YELLOW  = 4'd2,
      PH_ALLRED  = 4'd3,
      PH_SGREEN  = 4'd4,
      PH_SYELLOW = 4'd5,
      PH_NOFF    = 4'd6,
      PH_NON     = 4'd7,
      PH_HALT    = 4'd8
   } phase_type;

   typedef enum logic [2:0] {
      CSR_MIN_GREEN   = 3'd0,
      CSR_YELLOW      = 3'd1,
      CSR_ALL_RED     = 3'd2,
      CSR_SEC_GREEN   = 3'd3,
      CSR_STARTUP_OFF = 3'd4,
      CSR_BLINK_HALF  = 3'd5,
      CSR_SPEED_LIMIT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [TickWidth-1:0] min_green;
      logic [TickWidth-1:0] yellow;
      logic [TickWidth-1:0] all_red;
      logic [TickWidth-1:0] sec_green;
      logic [TickWidth-1:0] startup_off;
      logic [TickWidth-1:0] blink_half;
      logic [TickWidth-1:0] speed_limit;
   } tlpc_cfg_type;

   typedef struct packed {
      lamp_type              main_light;
      lamp_type              secondary_light;
      logic [CountWidth-1:0] main_red_count;
      logic [CountWidth-1:0] secondary_red_count;
      logic [CountWidth-1:0] speeding_count;
      logic                  halted;
   } tlpc_result_type;

   typedef struct packed {
      lamp_type main_lamp;
      lamp_type sec_lamp;
   } lamp_pair_type;

   // A zero length counts as one tick.
   function automatic logic [TickWidth-1:0] at_least_one(input logic [TickWidth-1:0] v);
      return (v == '0) ? {{(TickWidth-1){1'b0}}, 1'b1} : v;
   endfunction

   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   // Lamp pattern shown in each phase.
   function automatic lamp_pair_type phase_lamps(input phase_type ph);
      lamp_pair_type lp;
      case (ph)
         PH_GREEN:   lp = '{LAMP_GREEN, LAMP_RED};
         PH_YELLOW:  lp = '{LAMP_YELLOW, LAMP_RED};
         PH_ALLRED:  lp = '{LAMP_RED, LAMP_RED};
         PH_SGREEN:  lp = '{LAMP_RED, LAMP_GREEN};
         PH_SYELLOW: lp = '{LAMP_RED, LAMP_YELLOW};
         PH_NON:     lp = '{LAMP_YELLOW, LAMP_YELLOW};
         default:    lp = '{LAMP_OFF, LAMP_OFF};
      endcase
      return lp;
   endfunction

endpackage

`default_nettype wire

@@ src/tlpc_channels.sv @@
// Channel interfaces for requests, results and register writes.
`default_nettype none

interface tlpc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [1:0] mode_code;
   modport source (output valid, command, mode_code, input ready);
   modport sink (input valid, command, mode_code, output ready);
endinterface

interface tlpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  main_light;
   logic [1:0]  secondary_light;
   logic [15:0] main_red_count;
   logic [15:0] secondary_red_count;
   logic [15:0] speeding_count;
   logic        halted;
   modport source (output valid, main_light, secondary_light, main_red_count,
                   secondary_red_count, speeding_count, halted, input ready);
   modport sink (input valid, main_light, secondary_light, main_red_count,
                 secondary_red_count, speeding_count, halted, output ready);
endinterface

interface tlpc_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [23:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

@@ src/traffic_light_phase_controller.sv @@
// A request's result is formed combinationally and registered in the output register when the request is accepted.
// Throughput: one request per cycle; a new request is taken while a result waits,
// as long as that result is taken in the same cycle. The state update of the phase
// core for each accepted request sets this figure.
// Reset (synchronous): timing registers return to defaults, lamps off in the startup
// phase, counters cleared, no result pending.
`default_nettype none

module traffic_light_phase_controller import tlpc_pkg::*; (
   input wire logic   clock,
   input wire logic   reset,
   tlpc_req_if.sink   req_ch,
   tlpc_rsp_if.source rsp_ch,
   tlpc_csr_if.sink   csr_ch
);

   tlpc_cfg_type    cfg_ff, cfg_in;
   tlpc_result_type rsp_data_ff, rsp_data_in;
   logic            rsp_valid_ff, rsp_valid_in;
   tlpc_result_type core_result;
   logic            req_fire;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = 1'b1;

   // Register writes; indexes beyond the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_index_type'(csr_ch.index))
            CSR_MIN_GREEN:   cfg_in.min_green   = csr_ch.data;
            CSR_YELLOW:      cfg_in.yellow      = csr_ch.data;
            CSR_ALL_RED:     cfg_in.all_red     = csr_ch.data;
            CSR_SEC_GREEN:   cfg_in.sec_green   = csr_ch.data;
            CSR_STARTUP_OFF: cfg_in.startup_off = csr_ch.data;
            CSR_BLINK_HALF:  cfg_in.blink_half  = csr_ch.data;
            CSR_SPEED_LIMIT: cfg_in.speed_limit = csr_ch.data;
            default: ;
         endcase
      end
   end

   tlpc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .command   (cmd_type'(req_ch.command)),
      .mode_code (mode_type'(req_ch.mode_code)),
      .cfg       (cfg_ff),
      .result    (core_result)
   );

   // Output register: loads on each request, empties when the result is taken.
   always_comb begin
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff;
      if (req_fire) begin
         rsp_data_in  = core_result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_green   <= MIN_GREEN_RESET;
         cfg_ff.yellow      <= YELLOW_RESET;
         cfg_ff.all_red     <= ALL_RED_RESET;
         cfg_ff.sec_green   <= SEC_GREEN_RESET;
         cfg_ff.startup_off <= STARTUP_OFF_RESET;
         cfg_ff.blink_half  <= BLINK_HALF_RESET;
         cfg_ff.speed_limit <= SPEED_LIMIT_RESET;
         rsp_valid_ff       <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.main_light          = rsp_data_ff.main_light;
   assign rsp_ch.secondary_light     = rsp_data_ff.secondary_light;
   assign rsp_ch.main_red_count      = rsp_data_ff.main_red_count;
   assign rsp_ch.secondary_red_count = rsp_data_ff.secondary_red_count;
   assign rsp_ch.speeding_count      = rsp_data_ff.speeding_count;
   assign rsp_ch.halted              = rsp_data_ff.halted;

endmodule

`default_nettype wire

@@ src/tlpc_core.sv @@
// Phase sequencer, timers and infraction counters, updated once per request.
`default_nettype none

module tlpc_core import tlpc_pkg::*; (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_fire,
   input  wire cmd_type         command,
   input  wire mode_type        mode_code,
   input  wire tlpc_cfg_type    cfg,
   output tlpc_result_type      result
);

   phase_type             phase_ff, phase_in;
   logic [TickWidth-1:0]  phase_timer_ff, phase_timer_in;
   logic                  short_green_ff, short_green_in;
   logic [TickWidth-1:0]  gate_timer_ff, gate_timer_in;
   mode_type              pending_mode_ff, pending_mode_in;
   logic [BlinkWidth-1:0] blink_count_ff, blink_count_in;
   logic [CountWidth-1:0] main_red_ff, main_red_in;
   logic [CountWidth-1:0] sec_red_ff, sec_red_in;
   logic [CountWidth-1:0] speeding_ff, speeding_in;
   logic                  stopped_ff, stopped_in;

   logic [TickWidth-1:0]  min_green;
   logic [TickWidth-1:0]  long_green;
   logic [TickWidth-1:0]  phase_len;
   logic [TickWidth-1:0]  timer_inc;
   logic [BlinkWidth-1:0] blink_inc;
   lamp_pair_type         cur_lamps;
   lamp_pair_type         new_lamps;

   // Length of the current phase; long main green is twice the minimum, saturated.
   always_comb begin
      min_green  = at_least_one(cfg.min_green);
      long_green = min_green[TickWidth-1] ? TICK_MAX : {min_green[TickWidth-2:0], 1'b0};
      case (phase_ff)
         PH_STARTUP:         phase_len = cfg.startup_off;
         PH_GREEN:           phase_len = short_green_ff ? min_green : long_green;
         PH_YELLOW,
         PH_SYELLOW:         phase_len = at_least_one(cfg.yellow);
         PH_ALLRED:          phase_len = cfg.all_red;
         PH_SGREEN:          phase_len = at_least_one(cfg.sec_green);
         PH_NOFF, PH_NON:    phase_len = at_least_one(cfg.blink_half);
         default:            phase_len = TICK_MAX;
      endcase
   end

   // Next state for one accepted request.
   always_comb begin
      phase_in        = phase_ff;
      phase_timer_in  = phase_timer_ff;
      short_green_in  = short_green_ff;
      gate_timer_in   = gate_timer_ff;
      pending_mode_in = pending_mode_ff;
      blink_count_in  = blink_count_ff;
      main_red_in     = main_red_ff;
      sec_red_in      = sec_red_ff;
      speeding_in     = speeding_ff;
      stopped_in      = stopped_ff;
      cur_lamps       = phase_lamps(phase_ff);
      timer_inc       = (phase_timer_ff == TICK_MAX) ? phase_timer_ff : phase_timer_ff + 1'b1;
      blink_inc       = blink_count_ff + 1'b1;

      if (req_fire && !stopped_ff) begin
         case (command)
            CMD_TICK: begin
               if (gate_timer_ff != TICK_MAX) begin
                  gate_timer_in = gate_timer_ff + 1'b1;
               end
               phase_timer_in = timer_inc;
               if (timer_inc >= phase_len) begin
                  phase_timer_in = '0;
                  case (phase_ff)
                     PH_STARTUP, PH_SYELLOW: begin
                        // Cycle start: act on the latched remote mode and clear it.
                        pending_mode_in = MODE_NONE;
                        if (pending_mode_ff == MODE_NIGHT) begin
                           blink_count_in = '0;
                           phase_in       = PH_NOFF;
                        end else if (pending_mode_ff == MODE_CLOSE) begin
                           stopped_in = 1'b1;
                           phase_in   = PH_HALT;
                        end else begin
                           phase_in = PH_GREEN;
                        end
                     end
                     PH_GREEN: begin
                        short_green_in = 1'b0;
                        phase_in       = PH_YELLOW;
                     end
                     PH_YELLOW: begin
                        phase_in = (cfg.all_red == '0) ? PH_SGREEN : PH_ALLRED;
                     end
                     PH_ALLRED: phase_in = PH_SGREEN;
                     PH_SGREEN: phase_in = PH_SYELLOW;
                     PH_NOFF:   phase_in = PH_NON;
                     PH_NON: begin
                        // One full blink done; leave night mode after the last one.
                        if (blink_inc >= NIGHT_BLINKS) begin
                           blink_count_in = '0;
                           phase_in       = PH_GREEN;
                        end else begin
                           blink_count_in = blink_inc;
                           phase_in       = PH_NOFF;
                        end
                     end
                     default: phase_timer_in = timer_inc;
                  endcase
               end
            end
            CMD_PRESS:  short_green_in = 1'b1;
            CMD_GATE_A: gate_timer_in = '0;
            CMD_GATE_B: begin
               if (gate_timer_ff < at_least_one(cfg.speed_limit)) begin
                  speeding_in = sat_inc(speeding_ff);
               end
               if (cur_lamps.main_lamp == LAMP_RED) begin
                  main_red_in = sat_inc(main_red_ff);
               end
            end
            CMD_STOP_LINE: begin
               if (cur_lamps.sec_lamp == LAMP_RED) begin
                  sec_red_in = sat_inc(sec_red_ff);
               end
            end
            CMD_MODE: pending_mode_in = mode_code;
            default: ;
         endcase
      end

      // Result reflects the state after this request.
      new_lamps                  = phase_lamps(phase_in);
      result.main_light          = new_lamps.main_lamp;
      result.secondary_light     = new_lamps.sec_lamp;
      result.main_red_count      = main_red_in;
      result.secondary_red_count = sec_red_in;
      result.speeding_count      = speeding_in;
      result.halted              = stopped_in;
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_STARTUP;
         phase_timer_ff  <= '0;
         short_green_ff  <= 1'b0;
         gate_timer_ff   <= TICK_MAX;
         pending_mode_ff <= MODE_NONE;
         blink_count_ff  <= '0;
         main_red_ff     <= '0;
         sec_red_ff      <= '0;
         speeding_ff     <= '0;
         stopped_ff      <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         phase_timer_ff  <= phase_timer_in;
         short_green_ff  <= short_green_in;
         gate_timer_ff   <= gate_timer_in;
         pending_mode_ff <= pending_mode_in;
         blink_count_ff  <= blink_count_in;
         main_red_ff     <= main_red_in;
         sec_red_ff      <= sec_red_in;
         speeding_ff     <= speeding_in;
         stopped_ff      <= stopped_in;
      end
   end

endmodule

`default_nettype wire

@@ tb/tlpc_phase_checker.sv @@
// Checker that predicts the lamp and infraction status of every request and compares it.
`timescale 1ns / 1ps

module tlpc_phase_checker import tlpc_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   tlpc_req_if       req_mon,
   tlpc_rsp_if       rsp_mon,
   tlpc_csr_if       csr_mon,
   output int        mismatch_count,
   output int        outstanding
);

   // Timing registers as the block should hold them.
   tlpc_cfg_type timing;

   // Predicted controller state.
   phase_type       cur_phase;
   logic [23:0]     phase_ticks;
   logic [23:0]     gate_ticks;
   logic            short_green;
   mode_type        latched_mode;
   logic [6:0]      blinks_done;
   logic [15:0]     main_red_tally;
   logic [15:0]     sec_red_tally;
   logic [15:0]     speed_tally;
   logic            halted_now;

   // Status words still to come out of the block, oldest first.
   tlpc_result_type predicted_status_q[$];

   function automatic logic [23:0] floor_one(input logic [23:0] v);
      return (v == 24'd0) ? 24'd1 : v;
   endfunction

   function automatic logic [15:0] bump16(input logic [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
   endfunction

   // Lamps shown for a phase; startup, night off half and halt are dark.
   function automatic lamp_pair_type lamps_in(input phase_type p);
      lamp_pair_type lit;
      lit.main_lamp = LAMP_OFF;
      lit.sec_lamp  = LAMP_OFF;
      case (p)
         PH_GREEN: begin
            lit.main_lamp = LAMP_GREEN;
            lit.sec_lamp  = LAMP_RED;
         end
         PH_YELLOW: begin
            lit.main_lamp = LAMP_YELLOW;
            lit.sec_lamp  = LAMP_RED;
         end
         PH_ALLRED: begin
            lit.main_lamp = LAMP_RED;
            lit.sec_lamp  = LAMP_RED;
         end
         PH_SGREEN: begin
            lit.main_lamp = LAMP_RED;
            lit.sec_lamp  = LAMP_GREEN;
         end
         PH_SYELLOW: begin
            lit.main_lamp = LAMP_RED;
            lit.sec_lamp  = LAMP_YELLOW;
         end
         PH_NON: begin
            lit.main_lamp = LAMP_YELLOW;
            lit.sec_lamp  = LAMP_YELLOW;
         end
         default: ;
      endcase
      return lit;
   endfunction

   // Length in ticks of the phase the controller is in now.
   function automatic logic [23:0] length_now();
      logic [23:0] base;
      base = floor_one(timing.min_green);
      case (cur_phase)
         PH_STARTUP: return timing.startup_off;
         PH_GREEN: begin
            if (short_green) return base;
            if (base > (TICK_MAX >> 1)) return TICK_MAX;
            return base << 1;
         end
         PH_YELLOW, PH_SYELLOW: return floor_one(timing.yellow);
         PH_ALLRED: return timing.all_red;
         PH_SGREEN: return floor_one(timing.sec_green);
         PH_NOFF, PH_NON: return floor_one(timing.blink_half);
         default: return TICK_MAX;
      endcase
   endfunction

   function automatic void enter_phase(input phase_type p);
      cur_phase   = p;
      phase_ticks = 24'd0;
   endfunction

   // A new cycle acts on the latched remote mode and clears it.
   function automatic void start_cycle();
      mode_type m;
      m = latched_mode;
      latched_mode = MODE_NONE;
      if (m == MODE_NIGHT) begin
         blinks_done = 7'd0;
         enter_phase(PH_NOFF);
      end else if (m == MODE_CLOSE) begin
         halted_now = 1'b1;
         enter_phase(PH_HALT);
      end else begin
         enter_phase(PH_GREEN);
      end
   endfunction

   function automatic void advance_phase();
      case (cur_phase)
         PH_STARTUP: start_cycle();
         PH_GREEN: begin
            short_green = 1'b0;
            enter_phase(PH_YELLOW);
         end
         PH_YELLOW: begin
            if (timing.all_red == 24'd0) enter_phase(PH_SGREEN);
            else enter_phase(PH_ALLRED);
         end
         PH_ALLRED: enter_phase(PH_SGREEN);
         PH_SGREEN: enter_phase(PH_SYELLOW);
         PH_SYELLOW: start_cycle();
         PH_NOFF: enter_phase(PH_NON);
         PH_NON: begin
            blinks_done = blinks_done + 7'd1;
            if (blinks_done >= NIGHT_BLINKS) begin
               blinks_done = 7'd0;
               enter_phase(PH_GREEN);
            end else begin
               enter_phase(PH_NOFF);
            end
         end
         default: ;
      endcase
   endfunction

   // Apply one request to the predicted state and return the status it produces.
   function automatic tlpc_result_type step_controller(input logic [2:0] cmd,
                                                       input logic [1:0] code);
      lamp_pair_type   lit;
      tlpc_result_type status;
      if (!halted_now) begin
         lit = lamps_in(cur_phase);
         case (cmd)
            CMD_TICK: begin
               if (gate_ticks != TICK_MAX) gate_ticks = gate_ticks + 24'd1;
               if (phase_ticks != TICK_MAX) phase_ticks = phase_ticks + 24'd1;
               if (phase_ticks >= length_now()) advance_phase();
            end
            CMD_PRESS: short_green = 1'b1;
            CMD_GATE_A: gate_ticks = 24'd0;
            CMD_GATE_B: begin
               if (gate_ticks < floor_one(timing.speed_limit))
                  speed_tally = bump16(speed_tally);
               if (lit.main_lamp == LAMP_RED) main_red_tally = bump16(main_red_tally);
            end
            CMD_STOP_LINE: begin
               if (lit.sec_lamp == LAMP_RED) sec_red_tally = bump16(sec_red_tally);
            end
            CMD_MODE: latched_mode = mode_type'(code);
            default: ;
         endcase
      end
      lit = lamps_in(cur_phase);
      status.main_light          = lit.main_lamp;
      status.secondary_light     = lit.sec_lamp;
      status.main_red_count      = main_red_tally;
      status.secondary_red_count = sec_red_tally;
      status.speeding_count      = speed_tally;
      status.halted              = halted_now;
      return status;
   endfunction

   function automatic void reset_controller();
      timing.min_green   = MIN_GREEN_RESET;
      timing.yellow      = YELLOW_RESET;
      timing.all_red     = ALL_RED_RESET;
      timing.sec_green   = SEC_GREEN_RESET;
      timing.startup_off = STARTUP_OFF_RESET;
      timing.blink_half  = BLINK_HALF_RESET;
      timing.speed_limit = SPEED_LIMIT_RESET;
      cur_phase      = PH_STARTUP;
      phase_ticks    = 24'd0;
      gate_ticks     = TICK_MAX;
      short_green    = 1'b0;
      latched_mode   = MODE_NONE;
      blinks_done    = 7'd0;
      main_red_tally = 16'd0;
      sec_red_tally  = 16'd0;
      speed_tally    = 16'd0;
      halted_now     = 1'b0;
   endfunction

   function automatic void load_timing(input logic [2:0] idx, input logic [23:0] value);
      case (idx)
         CSR_MIN_GREEN:   timing.min_green   = value;
         CSR_YELLOW:      timing.yellow      = value;
         CSR_ALL_RED:     timing.all_red     = value;
         CSR_SEC_GREEN:   timing.sec_green   = value;
         CSR_STARTUP_OFF: timing.startup_off = value;
         CSR_BLINK_HALF:  timing.blink_half  = value;
         CSR_SPEED_LIMIT: timing.speed_limit = value;
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatch_count = mismatch_count + 1;
   endtask

   // Compare the status word taken from the block with the oldest prediction.
   task automatic check_status();
      tlpc_result_type want;
      if (predicted_status_q.size() == 0) begin
         report_mismatch("status word arrived with no request waiting");
         return;
      end
      want = predicted_status_q.pop_front();
      if (rsp_mon.main_light !== want.main_light)
         report_mismatch($sformatf("main_light got %0d, expected %0d",
                                   rsp_mon.main_light, want.main_light));
      if (rsp_mon.secondary_light !== want.secondary_light)
         report_mismatch($sformatf("secondary_light got %0d, expected %0d",
                                   rsp_mon.secondary_light, want.secondary_light));
      if (rsp_mon.main_red_count !== want.main_red_count)
         report_mismatch($sformatf("main_red_count got %0d, expected %0d",
                                   rsp_mon.main_red_count, want.main_red_count));
      if (rsp_mon.secondary_red_count !== want.secondary_red_count)
         report_mismatch($sformatf("secondary_red_count got %0d, expected %0d",
                                   rsp_mon.secondary_red_count, want.secondary_red_count));
      if (rsp_mon.speeding_count !== want.speeding_count)
         report_mismatch($sformatf("speeding_count got %0d, expected %0d",
                                   rsp_mon.speeding_count, want.speeding_count));
      if (rsp_mon.halted !== want.halted)
         report_mismatch($sformatf("halted got %0d, expected %0d",
                                   rsp_mon.halted, want.halted));
   endtask

   // Results are taken before new requests are predicted, since a request's
   // status can leave the block no earlier than the edge after it is accepted.
   always @(posedge clock) begin
      if (reset) begin
         reset_controller();
         predicted_status_q.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) check_status();
         if (csr_mon.valid && csr_mon.ready) load_timing(csr_mon.index, csr_mon.data);
         if (req_mon.valid && req_mon.ready)
            predicted_status_q.push_back(step_controller(req_mon.command,
                                                         req_mon.mode_code));
      end
      outstanding = predicted_status_q.size();
   end

endmodule

@@ tb/tb_traffic_light_phase_controller.sv @@
// Top of the traffic light phase controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_traffic_light_phase_controller;
   import tlpc_pkg::*;

   localparam int MaxGap     = 18;
   localparam int LongHold   = 150;
   localparam int HoldAt     = 60;
   localparam int StallLimit = 1000;

   // Command codes the block has no meaning for; they must change nothing.
   localparam logic [2:0] CMD_SPARE_6 = 3'd6;
   localparam logic [2:0] CMD_SPARE_7 = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;

   int  mismatch_total;
   int  pending_results;
   int  stalled_cycles = 0;
   bit  req_quiet = 1'b0;
   bit  saw_halt = 1'b0;

   tlpc_req_if req_ch ();
   tlpc_rsp_if rsp_ch ();
   tlpc_csr_if csr_ch ();

   traffic_light_phase_controller i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   tlpc_phase_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .csr_mon        (csr_ch),
      .mismatch_count (mismatch_total),
      .outstanding    (pending_results)
   );

   always #4 clock = ~clock;

   // Watchdog: the run ends if no channel moves anything for too long.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles >= StallLimit) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // Result side: a random wait before each status word, with one long hold-off
   // early on so that the block backs up and stalls its request input.
   initial begin : status_sink
      int  wait_cycles;
      int  taken;
      bit  quiet;
      rsp_ch.ready = 1'b0;
      taken = 0;
      quiet = 1'b0;
      wait (reset == 1'b0);
      forever begin
         wait_cycles = quiet ? 0 : $urandom_range(0, MaxGap);
         if ($urandom_range(0, 49) == 0) quiet = !quiet;
         if (taken == HoldAt) wait_cycles = LongHold;
         @(negedge clock);
         if (wait_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (rsp_ch.valid !== 1'b1);
         if (rsp_ch.halted === 1'b1) saw_halt = 1'b1;
         taken++;
      end
   end

   // Offer one request after a random gap and hold it until it is accepted.
   task automatic send_request(input logic [2:0] cmd, input logic [1:0] code);
      int gap;
      gap = req_quiet ? 0 : $urandom_range(0, MaxGap);
      if ($urandom_range(0, 49) == 0) req_quiet = !req_quiet;
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.command   <= cmd;
      req_ch.mode_code <= code;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
   endtask

   // Stop offering and wait until every predicted status word has come out.
   task automatic wait_idle();
      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (pending_results != 0) @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_register(input csr_index_type idx, input logic [23:0] value);
      @(negedge clock);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      do @(posedge clock); while (csr_ch.ready !== 1'b1);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic program_timing(input logic [23:0] min_green, input logic [23:0] yellow,
                                 input logic [23:0] all_red, input logic [23:0] sec_green,
                                 input logic [23:0] startup_off,
                                 input logic [23:0] blink_half,
                                 input logic [23:0] speed_limit);
      wait_idle();
      write_register(CSR_MIN_GREEN, min_green);
      write_register(CSR_YELLOW, yellow);
      write_register(CSR_ALL_RED, all_red);
      write_register(CSR_SEC_GREEN, sec_green);
      write_register(CSR_STARTUP_OFF, startup_off);
      write_register(CSR_BLINK_HALF, blink_half);
      write_register(CSR_SPEED_LIMIT, speed_limit);
   endtask

   // Mostly ticks, so the phases keep turning; sensors, presses and the odd
   // remote mode in between. Close is kept out here, since it halts for good.
   task automatic random_item(input bit modes_ok);
      int         pick;
      logic [1:0] code;
      pick = $urandom_range(0, 99);
      code = 2'($urandom_range(0, 3));
      if (pick < 55) begin
         send_request(CMD_TICK, code);
      end else if (pick < 63) begin
         send_request(CMD_PRESS, code);
      end else if (pick < 72) begin
         send_request(CMD_GATE_A, code);
      end else if (pick < 82) begin
         send_request(CMD_GATE_B, code);
      end else if (pick < 90) begin
         send_request(CMD_STOP_LINE, code);
      end else if (pick < 95 && modes_ok) begin
         pick = $urandom_range(0, 19);
         if (pick < 2) code = MODE_NIGHT;
         else if (pick < 11) code = MODE_EMERGENCY;
         else code = MODE_NONE;
         send_request(CMD_MODE, code);
      end else if (pick < 95) begin
         send_request(CMD_TICK, code);
      end else if (pick < 97) begin
         send_request(CMD_SPARE_6, code);
      end else begin
         send_request(CMD_SPARE_7, code);
      end
      // Now and then the sender waits for the block to drain completely.
      if ($urandom_range(0, 99) == 0) wait_idle();
   endtask

   task automatic run_random(input int count);
      repeat (count) random_item(1'b1);
   endtask

   initial begin : stimulus
      int sent;
      req_ch.valid     = 1'b0;
      req_ch.command   = CMD_TICK;
      req_ch.mode_code = MODE_NONE;
      csr_ch.valid     = 1'b0;
      csr_ch.index     = CSR_MIN_GREEN;
      csr_ch.data      = 24'd0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Still in the dark startup phase: sensors count no red, gate B with no
      // gate A seen is not speeding, unknown commands and stray mode bits do nothing.
      send_request(CMD_GATE_B, MODE_NONE);
      send_request(CMD_STOP_LINE, MODE_NONE);
      send_request(CMD_SPARE_6, MODE_CLOSE);
      send_request(CMD_SPARE_7, MODE_NIGHT);
      send_request(CMD_GATE_A, MODE_CLOSE);
      send_request(CMD_GATE_B, MODE_NONE);
      send_request(CMD_MODE, MODE_NONE);
      send_request(CMD_PRESS, MODE_NONE);
      send_request(CMD_TICK, MODE_NONE);

      // Short phases with a zero startup: the next tick opens a shortened green,
      // then a walk through yellow, all red and the secondary phases.
      program_timing(24'd3, 24'd2, 24'd1, 24'd2, 24'd0, 24'd1, 24'd4);
      repeat (4) send_request(CMD_TICK, MODE_NONE);
      send_request(CMD_GATE_B, MODE_NONE);
      send_request(CMD_STOP_LINE, MODE_NONE);
      repeat (2) send_request(CMD_TICK, MODE_NONE);
      send_request(CMD_GATE_A, MODE_NONE);
      send_request(CMD_GATE_B, MODE_NONE);
      send_request(CMD_TICK, MODE_NONE);
      send_request(CMD_STOP_LINE, MODE_NONE);
      send_request(CMD_MODE, MODE_EMERGENCY);
      repeat (4) send_request(CMD_TICK, MODE_NONE);
      run_random(550);

      // All lengths zero: they count as one tick, and the all red is skipped.
      program_timing(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      run_random(300);

      // Largest values: long green saturates, every gate pair is speeding.
      program_timing(TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX);
      run_random(80);

      program_timing(24'($urandom_range(0, 6)), 24'($urandom_range(0, 6)),
                     24'($urandom_range(0, 6)), 24'($urandom_range(0, 6)),
                     24'($urandom_range(0, 6)), 24'($urandom_range(0, 6)),
                     24'($urandom_range(0, 6)));
      run_random(500);

      program_timing(24'($urandom_range(1, 40)), 24'($urandom_range(1, 40)),
                     24'($urandom_range(0, 10)), 24'($urandom_range(1, 40)),
                     24'($urandom_range(1, 40)), 24'($urandom_range(1, 3)),
                     24'($urandom_range(1, 30)));
      run_random(300);

      // Close comes last: once halted the block ignores every request until reset.
      program_timing(24'd2, 24'd1, 24'd1, 24'd2, 24'd0, 24'd1, 24'd3);
      send_request(CMD_MODE, MODE_CLOSE);
      sent = 0;
      while (!saw_halt && sent < 1000) begin
         if ($urandom_range(0, 4) != 0) send_request(CMD_TICK, 2'($urandom_range(0, 3)));
         else random_item(1'b0);
         sent++;
      end
      repeat (30) random_item(1'b0);

      wait_idle();
      repeat (10) @(negedge clock);
      if (mismatch_total == 0 && pending_results == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/tlpc_pkg.sv
src/tlpc_channels.sv
src/tlpc_core.sv
src/traffic_light_phase_controller.sv
tb/tlpc_phase_checker.sv
tb/tb_traffic_light_phase_controller.sv
